FILE: rtl/windowed_peak_background_integrator_defines.svh
// assertion macros shared by the windowed peak background integrator
`ifndef WINDOWED_PEAK_BACKGROUND_INTEGRATOR_DEFINES_SVH
`define WINDOWED_PEAK_BACKGROUND_INTEGRATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define WPBI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wpbi check failed");

// next-cycle implication, disabled during reset
`define WPBI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wpbi check failed");

`endif

FILE: rtl/wpbi_pkg.sv
// types, codes and constants of the windowed peak background integrator
package wpbi_pkg;

  localparam int unsigned BIN_W      = 32;
  localparam int unsigned EXT_W      = 63;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned SEL_W      = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam logic [LEN_W-1:0] RECORD_LENGTH_RESET = 32'd1024;
  localparam logic [LEN_W-1:0] MIN_EXCESS_RESET    = 32'd100;

  typedef enum logic [1:0] {
    REG_RECORD_LENGTH = 2'd0,
    REG_MODE          = 2'd1,
    REG_MIN_EXCESS    = 2'd2,
    REG_OUTPUT_SELECT = 2'd3
  } reg_idx_t;

  localparam logic [MODE_W-1:0] MODE_TOTAL     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CORRECTED = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RATIO     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EXTERNAL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EXT_RATIO = 3'd4;

  localparam logic [SEL_W-1:0] SEL_NORMAL     = 2'd0;
  localparam logic [SEL_W-1:0] SEL_RAW        = 2'd1;
  localparam logic [SEL_W-1:0] SEL_BACKGROUND = 2'd2;

  localparam logic [STAT_W-1:0] ST_VALID    = 2'd0;
  localparam logic [STAT_W-1:0] ST_BELOW    = 2'd1;
  localparam logic [STAT_W-1:0] ST_DIV_ZERO = 2'd2;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic [BIN_W-1:0] bin_count;
    logic [EXT_W-1:0] ext_background;
    logic             last_bin;
  } bin_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [STAT_W-1:0]         status;
  } result_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  record_length;
    logic [LEN_W-1:0]  q1;
    logic [LEN_W-1:0]  q3;
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  min_excess;
    logic [SEL_W-1:0]  output_select;
  } wpbi_cfg_t;

  typedef struct packed {
    logic accum;
    logic prep;
    logic judge;
    logic div_step;
    logic take_quot;
    logic emit;
  } wpbi_cmd_t;

  typedef struct packed {
    logic bin_fire;
    logic bin_last;
    logic go_div;
    logic div_last;
    logic out_free;
  } wpbi_stat_t;

endpackage

FILE: rtl/windowed_peak_background_integrator.sv
// top level of the windowed peak background integrator
// Usage:
//  bin channel (bin_valid, bin_stall, bin_item): one histogram bin per
//  transaction, carrying bin_count, ext_background and last_bin. Bins are
//  taken one per cycle while a record is being gathered.
//  result channel (result_valid, result_stall, result_item): one transaction
//  per record, signed Q.FRACTION_BITS value and a status code.
//  After the last_bin transaction the block raises bin_stall while it forms
//  the result in the PREP, JUDGE and EMIT states for non-ratio results and
//  for ratios that end below threshold or on a zero background; a ratio that
//  is divided also passes through DIVIDE and QUOT (one quotient bit per cycle
//  in the restoring divider) before EMIT.
//  The result sits in an output register; if result_stall holds it there,
//  the finished result of the next record waits until it is taken, and bins
//  for a new record are accepted as soon as the result has been loaded.
//  Configuration through the APB port is expected while no record is open.
//  Synchronous reset clears the sums, the bin index, the result valid flag and
//  loads the register defaults (1024 bins, mode total, threshold 100).
`include "windowed_peak_background_integrator_defines.svh"

module windowed_peak_background_integrator #(
  parameter int unsigned FRACTION_BITS = wpbi_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                bin_valid,
  output logic                                bin_stall,
  input  wpbi_pkg::bin_item_t                 bin_item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output wpbi_pkg::result_item_t              result_item,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wpbi_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [wpbi_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [wpbi_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import wpbi_pkg::*;

  wpbi_cfg_t  cfg;
  wpbi_cmd_t  cmd;
  wpbi_stat_t stat;
  logic       bin_fire;
  logic       cfg_wr;
  reg_idx_t   reg_idx;
  logic [LEN_W+1:0] len_x3;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign reg_idx  = reg_idx_t'(paddr[3:2]);
  assign len_x3   = {2'b00, pwdata} + {1'b0, pwdata, 1'b0};
  assign bin_fire = bin_valid && !bin_stall;

  // quarter boundaries are computed once when the length is written
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.record_length <= RECORD_LENGTH_RESET;
      cfg.q1            <= RECORD_LENGTH_RESET >> 2;
      cfg.q3            <= LEN_W'((RECORD_LENGTH_RESET * 3) >> 2);
      cfg.mode          <= MODE_TOTAL;
      cfg.min_excess    <= MIN_EXCESS_RESET;
      cfg.output_select <= SEL_NORMAL;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RECORD_LENGTH: begin
          cfg.record_length <= pwdata;
          cfg.q1            <= {2'b00, pwdata[LEN_W-1:2]};
          cfg.q3            <= len_x3[LEN_W+1:2];
        end
        REG_MODE:          cfg.mode          <= pwdata[MODE_W-1:0];
        REG_MIN_EXCESS:    cfg.min_excess    <= pwdata;
        REG_OUTPUT_SELECT: cfg.output_select <= pwdata[SEL_W-1:0];
        default:           cfg.mode          <= cfg.mode;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RECORD_LENGTH: prdata = cfg.record_length;
      REG_MODE:          prdata = APB_DATA_W'(cfg.mode);
      REG_MIN_EXCESS:    prdata = cfg.min_excess;
      REG_OUTPUT_SELECT: prdata = APB_DATA_W'(cfg.output_select);
      default:           prdata = '0;
    endcase
  end

  wpbi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .cmd       (cmd),
    .bin_stall (bin_stall)
  );

  wpbi_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .bin_item     (bin_item),
    .bin_fire     (bin_fire),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  // no bins are taken between the end of a record and its result
  `WPBI_ASSERT_NEXT(a_stall_after_last, clk, rst, bin_fire && bin_item.last_bin, bin_stall)
  // a new result only appears out of the end-of-record sequence
  `WPBI_ASSERT_NOW(a_result_from_seq, clk, rst, $rose(result_valid), $past(bin_stall))
  // the divider never runs while bins are being accepted
  `WPBI_ASSERT_NOW(a_div_stalls_bins, clk, rst, cmd.div_step, bin_stall)

endmodule

FILE: rtl/wpbi_ctrl.sv
// controller of the integrator: record accumulation and end-of-record sequencing
module wpbi_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  wpbi_pkg::wpbi_stat_t stat,
  output wpbi_pkg::wpbi_cmd_t  cmd,
  output logic               bin_stall
);
  import wpbi_pkg::*;

  typedef enum logic [2:0] {
    ACCUM,
    PREP,
    JUDGE,
    DIVIDE,
    QUOT,
    EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ACCUM: begin
        if (stat.bin_fire && stat.bin_last) state_next = PREP;
      end
      PREP:  state_next = JUDGE;
      JUDGE: state_next = stat.go_div ? DIVIDE : EMIT;
      DIVIDE: begin
        if (stat.div_last) state_next = QUOT;
      end
      QUOT: state_next = EMIT;
      EMIT: begin
        if (stat.out_free) state_next = ACCUM;
      end
      default: state_next = ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.accum     = (state == ACCUM) && stat.bin_fire;
    cmd.prep      = (state == PREP);
    cmd.judge     = (state == JUDGE);
    cmd.div_step  = (state == DIVIDE);
    cmd.take_quot = (state == QUOT);
    cmd.emit      = (state == EMIT) && stat.out_free;
  end

  assign bin_stall = (state != ACCUM);

endmodule

FILE: rtl/wpbi_datapath.sv
// datapath of the integrator: running sums, result forming, divider, result register
module wpbi_datapath #(
  parameter int unsigned FRACTION_BITS = wpbi_pkg::FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  wpbi_pkg::wpbi_cfg_t     cfg,
  input  wpbi_pkg::wpbi_cmd_t     cmd,
  output wpbi_pkg::wpbi_stat_t    stat,
  input  wpbi_pkg::bin_item_t     bin_item,
  input  logic                    bin_fire,
  output logic                    result_valid,
  input  logic                    result_stall,
  output wpbi_pkg::result_item_t  result_item
);
  import wpbi_pkg::*;

  // magnitude, dividend, divisor and partial remainder widths
  localparam int unsigned AW = SUM_W + 1 + FRACTION_BITS;
  localparam int unsigned NW = AW + FRACTION_BITS;
  localparam int unsigned DW = SUM_W + 1;
  localparam int unsigned RW = DW + 1;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [LEN_W-1:0] bin_index;
  logic [SUM_W-1:0] full_sum;
  logic [SUM_W-1:0] central_sum;
  logic [SUM_W-1:0] outer_sum;
  logic [EXT_W-1:0] ext_bg;

  logic in_len;
  logic in_outer;
  logic [SUM_W-1:0] count_w;

  assign in_len   = bin_index < cfg.record_length;
  assign in_outer = (bin_index < cfg.q1) || (bin_index >= cfg.q3);
  assign count_w  = SUM_W'(bin_item.bin_count);

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      bin_index   <= '0;
      full_sum    <= '0;
      central_sum <= '0;
      outer_sum   <= '0;
    end else if (cmd.accum) begin
      if (in_len) begin
        full_sum <= full_sum + count_w;
        if (in_outer) outer_sum <= outer_sum + count_w;
        else central_sum <= central_sum + count_w;
      end
      if (bin_index != '1) bin_index <= bin_index + 1'b1;
    end
  end

  // external background is only used from the last bin of the record
  always_ff @(posedge clk) begin
    if (cmd.accum && bin_item.last_bin) ext_bg <= bin_item.ext_background;
  end

  // operand selection
  logic [MODE_W-1:0] mode_n;
  logic [AW-1:0] full_w, cen_w, bg_w, ext_w;
  logic [AW-1:0] full_sh, cen_sh, bg_sh;
  logic [AW-1:0] min_w, min_sh;
  logic [AW-1:0] op_a, op_b, th_sel;
  logic [DW-1:0] dvs_sel;
  logic          ratio_sel;

  assign mode_n  = (cfg.mode > MODE_EXT_RATIO) ? MODE_TOTAL : cfg.mode;
  assign full_w  = AW'(full_sum);
  assign cen_w   = AW'(central_sum);
  assign bg_w    = AW'({outer_sum, 1'b0});
  assign ext_w   = AW'(ext_bg);
  assign full_sh = full_w << FRACTION_BITS;
  assign cen_sh  = cen_w << FRACTION_BITS;
  assign bg_sh   = bg_w << FRACTION_BITS;
  assign min_w   = AW'(cfg.min_excess);
  assign min_sh  = min_w << FRACTION_BITS;

  always_comb begin
    op_a      = full_sh;
    op_b      = '0;
    th_sel    = min_w;
    dvs_sel   = DW'(ext_bg);
    ratio_sel = 1'b0;
    if (cfg.output_select == SEL_RAW) begin
      op_a = ((mode_n == MODE_EXTERNAL) || (mode_n == MODE_EXT_RATIO)) ? cen_sh : full_sh;
    end else begin
      case (mode_n)
        MODE_CORRECTED: begin
          op_a = full_sh;
          op_b = bg_sh;
        end
        MODE_RATIO: begin
          if (cfg.output_select == SEL_BACKGROUND) begin
            op_a = bg_sh;
          end else begin
            op_a      = full_w;
            op_b      = bg_w;
            th_sel    = min_w;
            dvs_sel   = {outer_sum, 1'b0};
            ratio_sel = 1'b1;
          end
        end
        MODE_EXTERNAL: begin
          op_a = cen_sh;
          op_b = ext_w;
        end
        MODE_EXT_RATIO: begin
          if (cfg.output_select == SEL_BACKGROUND) begin
            op_a = ext_w;
          end else begin
            op_a      = cen_sh;
            op_b      = ext_w;
            th_sel    = min_sh;
            dvs_sel   = DW'(ext_bg);
            ratio_sel = 1'b1;
          end
        end
        default: op_a = full_sh;
      endcase
    end
  end

  // signed difference and ratio context
  logic [AW:0]   diff;
  logic [AW-1:0] th;
  logic [DW-1:0] dvs;
  logic          ratio;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      diff  <= {1'b0, op_a} - {1'b0, op_b};
      th    <= th_sel;
      dvs   <= dvs_sel;
      ratio <= ratio_sel;
    end
  end

  logic neg, below, dvs_zero, in_range;
  logic [VALUE_W-1:0] diff_sat;

  assign neg      = diff[AW];
  assign below    = neg || (diff[AW-1:0] < th);
  assign dvs_zero = (dvs == '0);
  // fits int64 when every bit from 63 up equals the sign
  assign in_range = (&diff[AW:VALUE_W-1]) || !(|diff[AW:VALUE_W-1]);
  assign diff_sat = in_range ? diff[VALUE_W-1:0] : (neg ? VALUE_MIN : VALUE_MAX);

  // restoring divider, one quotient bit a cycle; quotient shifts into num
  logic [NW-1:0] num;
  logic [RW-1:0] rem;
  logic [CW-1:0] div_cnt;
  logic [RW-1:0] rem_sh;
  logic          q_bit;

  assign rem_sh = {rem[RW-2:0], num[NW-1]};
  assign q_bit  = rem_sh >= RW'(dvs);

  always_ff @(posedge clk) begin
    if (cmd.judge) begin
      num     <= {diff[AW-1:0], {FRACTION_BITS{1'b0}}};
      rem     <= '0;
      div_cnt <= CW'(NW);
    end else if (cmd.div_step) begin
      rem     <= q_bit ? (rem_sh - RW'(dvs)) : rem_sh;
      num     <= {num[NW-2:0], q_bit};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // pending result
  logic [VALUE_W-1:0] res_value;
  logic [STAT_W-1:0]  res_status;

  always_ff @(posedge clk) begin
    if (cmd.judge) begin
      if (ratio) begin
        res_value  <= '0;
        res_status <= below ? ST_BELOW : (dvs_zero ? ST_DIV_ZERO : ST_VALID);
      end else begin
        res_value  <= diff_sat;
        res_status <= ST_VALID;
      end
    end else if (cmd.take_quot) begin
      res_value <= (|num[NW-1:VALUE_W-1]) ? VALUE_MAX : num[VALUE_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_item.value  <= res_value;
      result_item.status <= res_status;
    end
  end

  always_comb begin
    stat          = '0;
    stat.bin_fire = bin_fire;
    stat.bin_last = bin_item.last_bin;
    stat.go_div   = ratio && !below && !dvs_zero;
    stat.div_last = (div_cnt == CW'(1));
    stat.out_free = !result_valid || !result_stall;
  end

endmodule
